// ===== design/vpcv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpcv_pkg: shared types and constants for the vertex projection core
// Holds the payload structs, the queue entry and the fixed widths.
// ----------------------------------------------------------------------------
package vpcv_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int FRAC_BITS_MIN = 8;
	// Clip sums need 66 - FRAC_BITS bits; sized for the smallest fraction.
	localparam int CLIP_W = 66 - FRAC_BITS_MIN;
	localparam int SIZE_W = 12;
	localparam int QUO_W = 33;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_PROJECT = 1'b1;

	typedef struct packed {
		logic op;
		logic [3:0] coef_index;
		logic signed [31:0] coef_value;
		logic signed [31:0] vertex_x;
		logic signed [31:0] vertex_y;
		logic signed [31:0] vertex_z;
	} in_item_t;

	typedef struct packed {
		logic visible;
		logic [15:0] screen_x;
		logic [15:0] screen_y;
	} out_item_t;

	// Classified vertex handed from the front to the back.
	typedef struct packed {
		logic visible;
		logic [CLIP_W:0] num_x;
		logic [CLIP_W:0] num_y;
		logic [CLIP_W:0] den;
	} clip_item_t;

	typedef struct packed {
		logic push;
		logic pop;
	} queue_ctl_t;

endpackage

// ===== design/vpcv_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpcv_front: matrix store, transform and clip classification
// Three stages: products, row sums, clip test and numerator setup.
// ----------------------------------------------------------------------------
module vpcv_front #(
	parameter int FRAC_BITS = vpcv_pkg::FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  vpcv_pkg::in_item_t     item,
	output logic                   push,
	output vpcv_pkg::clip_item_t   push_item
);
	import vpcv_pkg::*;

	localparam int CMP_W = CLIP_W + 16;
	localparam logic [CMP_W-1:0] ONE_CMP = CMP_W'(1) << FRAC_BITS;

	logic signed [31:0] mat_q [16];
	logic signed [63:0] prod_s1 [12];
	logic signed [31:0] col3_s1 [4];
	logic valid_s1, valid_s2, valid_s3;
	logic signed [CLIP_W-1:0] clip_s2 [4];
	logic signed [CLIP_W-1:0] clip_comb [4];
	clip_item_t item_s3, item_comb;

	logic [CLIP_W-1:0] aw, ax, ay, az;
	logic signed [CLIP_W:0] sx, sy, nx, ny;
	logic near_zero, outside;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				mat_q[i] <= (i % 5 == 0) ? (32'sd1 <<< FRAC_BITS) : 32'sd0;
			end
		end else if (accept && item.op == OP_LOAD) begin
			mat_q[item.coef_index] <= item.coef_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= accept && item.op == OP_PROJECT;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < 4; r++) begin
			prod_s1[r*3+0] <= 64'(mat_q[r*4+0]) * 64'(item.vertex_x);
			prod_s1[r*3+1] <= 64'(mat_q[r*4+1]) * 64'(item.vertex_y);
			prod_s1[r*3+2] <= 64'(mat_q[r*4+2]) * 64'(item.vertex_z);
			col3_s1[r] <= mat_q[r*4+3];
		end
		clip_s2 <= clip_comb;
		item_s3 <= item_comb;
	end

	// Floor shift of each product, then the exact row sum.
	always_comb begin
		for (int r = 0; r < 4; r++) begin
			clip_comb[r] = CLIP_W'(prod_s1[r*3+0] >>> FRAC_BITS)
				+ CLIP_W'(prod_s1[r*3+1] >>> FRAC_BITS)
				+ CLIP_W'(prod_s1[r*3+2] >>> FRAC_BITS)
				+ CLIP_W'(col3_s1[r]);
		end
	end

	always_comb begin
		aw = clip_s2[3][CLIP_W-1] ? CLIP_W'(-clip_s2[3]) : CLIP_W'(clip_s2[3]);
		ax = clip_s2[0][CLIP_W-1] ? CLIP_W'(-clip_s2[0]) : CLIP_W'(clip_s2[0]);
		ay = clip_s2[1][CLIP_W-1] ? CLIP_W'(-clip_s2[1]) : CLIP_W'(clip_s2[1]);
		az = clip_s2[2][CLIP_W-1] ? CLIP_W'(-clip_s2[2]) : CLIP_W'(clip_s2[2]);
		// The w threshold is 2^-16 whatever the fraction width.
		near_zero = (CMP_W'(aw) < ONE_CMP) && ({aw, 16'd0} < ONE_CMP);
		outside = (ax > aw) || (ay > aw) || (az > aw);
		sx = clip_s2[3][CLIP_W-1] ? -(CLIP_W+1)'(clip_s2[0]) : (CLIP_W+1)'(clip_s2[0]);
		sy = clip_s2[3][CLIP_W-1] ? -(CLIP_W+1)'(clip_s2[1]) : (CLIP_W+1)'(clip_s2[1]);
		nx = $signed({1'b0, aw}) + sx;
		ny = $signed({1'b0, aw}) - sy;
		item_comb.visible = !near_zero && !outside;
		item_comb.num_x = nx;
		item_comb.num_y = ny;
		item_comb.den = {aw, 1'b0};
	end

	assign push = valid_s3;
	assign push_item = item_s3;

endmodule

// ===== design/vpcv_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpcv_queue: short queue between the front and the back
// A small register file with a head and tail pointer.
// ----------------------------------------------------------------------------
module vpcv_queue #(
	parameter int DEPTH = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  vpcv_pkg::queue_ctl_t   ctl,
	input  vpcv_pkg::clip_item_t   wr_item,
	output logic                   not_empty,
	output vpcv_pkg::clip_item_t   rd_item
);
	import vpcv_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);

	clip_item_t entry_q [DEPTH];
	logic [PTR_W-1:0] head_q, tail_q;
	logic [PTR_W:0] count_q;

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			entry_q[tail_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
		end else begin
			if (ctl.push) begin
				tail_q <= (tail_q == PTR_W'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
			end
			if (ctl.pop) begin
				head_q <= (head_q == PTR_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;
			end
			count_q <= count_q + (PTR_W+1)'(ctl.push) - (PTR_W+1)'(ctl.pop);
		end
	end

	assign not_empty = count_q != '0;
	assign rd_item = entry_q[head_q];

endmodule

// ===== design/vpcv_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpcv_back: pipelined division and viewport mapping
// One quotient bit per stage for both axes, then scale, round and saturate.
// ----------------------------------------------------------------------------
module vpcv_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              head_valid,
	input  vpcv_pkg::clip_item_t              head_item,
	input  logic [vpcv_pkg::SIZE_W-1:0]       screen_width,
	input  logic [vpcv_pkg::SIZE_W-1:0]       screen_height,
	output logic                              pop,
	output logic                              out_valid,
	input  logic                              out_stall,
	output vpcv_pkg::out_item_t               out_data
);
	import vpcv_pkg::*;

	localparam int NST = QUO_W;
	localparam int RW = CLIP_W + 1;
	localparam int MW = QUO_W + SIZE_W + 4;

	logic en;
	logic vld_s [NST];
	logic vis_s [NST];
	logic [RW-1:0] den_s [NST];
	logic [RW-1:0] rx_s [NST];
	logic [RW-1:0] ry_s [NST];
	logic [QUO_W-1:0] qx_s [NST];
	logic [QUO_W-1:0] qy_s [NST];
	logic vld_m, vis_m;
	logic [MW-1:0] mx_m, my_m;
	logic [MW-1:0] rnd_x, rnd_y;
	logic [MW-33:0] sx, sy;
	logic [15:0] lim_x, lim_y;

	// The whole back moves together whenever the output slot can take data.
	assign en = !out_valid || !out_stall;
	assign pop = en && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NST; k++) begin
				vld_s[k] <= 1'b0;
			end
			vld_m <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			vld_s[0] <= head_valid;
			for (int k = 1; k < NST; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
			vld_m <= vld_s[NST-1];
			out_valid <= vld_m;
		end
	end

	// First quotient bit is the integer part: it is one when n is at least d, which for a visible vertex means n equals d.
	always_ff @(posedge clk) begin
		if (en) begin
			vis_s[0] <= head_item.visible;
			den_s[0] <= head_item.den;
			if (head_item.num_x >= head_item.den) begin
				rx_s[0] <= head_item.num_x - head_item.den;
				qx_s[0] <= QUO_W'(1);
			end else begin
				rx_s[0] <= head_item.num_x;
				qx_s[0] <= '0;
			end
			if (head_item.num_y >= head_item.den) begin
				ry_s[0] <= head_item.num_y - head_item.den;
				qy_s[0] <= QUO_W'(1);
			end else begin
				ry_s[0] <= head_item.num_y;
				qy_s[0] <= '0;
			end
		end
	end

	for (genvar k = 1; k < NST; k++) begin : g_div
		logic [RW:0] tx, ty;
		assign tx = {rx_s[k-1], 1'b0};
		assign ty = {ry_s[k-1], 1'b0};
		always_ff @(posedge clk) begin
			if (en) begin
				vis_s[k] <= vis_s[k-1];
				den_s[k] <= den_s[k-1];
				if (tx >= {1'b0, den_s[k-1]}) begin
					rx_s[k] <= RW'(tx - {1'b0, den_s[k-1]});
					qx_s[k] <= {qx_s[k-1][QUO_W-2:0], 1'b1};
				end else begin
					rx_s[k] <= RW'(tx);
					qx_s[k] <= {qx_s[k-1][QUO_W-2:0], 1'b0};
				end
				if (ty >= {1'b0, den_s[k-1]}) begin
					ry_s[k] <= RW'(ty - {1'b0, den_s[k-1]});
					qy_s[k] <= {qy_s[k-1][QUO_W-2:0], 1'b1};
				end else begin
					ry_s[k] <= RW'(ty);
					qy_s[k] <= {qy_s[k-1][QUO_W-2:0], 1'b0};
				end
			end
		end
	end

	assign lim_x = {screen_width, 4'd0};
	assign lim_y = {screen_height, 4'd0};

	always_ff @(posedge clk) begin
		if (en) begin
			vis_m <= vis_s[NST-1];
			mx_m <= MW'(qx_s[NST-1]) * MW'(lim_x);
			my_m <= MW'(qy_s[NST-1]) * MW'(lim_y);
		end
	end

	always_comb begin
		rnd_x = mx_m + (MW'(1) << 31);
		rnd_y = my_m + (MW'(1) << 31);
		sx = rnd_x[MW-1:32];
		sy = rnd_y[MW-1:32];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data.visible <= vis_m;
			if (!vis_m) begin
				out_data.screen_x <= '0;
				out_data.screen_y <= '0;
			end else begin
				out_data.screen_x <= (sx > (MW-32)'(lim_x)) ? lim_x : sx[15:0];
				out_data.screen_y <= (sy > (MW-32)'(lim_y)) ? lim_y : sy[15:0];
			end
		end
	end

endmodule

// ===== design/vertex_project_clip_viewport_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_project_clip_viewport_core: fixed-point vertex transform and viewport
// Top level joining the classifying front, the queue and the dividing back.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on in_valid/in_stall/in_data. A load item writes one matrix
// coefficient and produces nothing; a project item produces exactly one
// transfer on out_valid/out_stall/out_data, in order.
// Throughput is one item per cycle while nothing stalls. A project item passes
// the three front stages (products, row sums, clip test) and the queue
// register, then 33 divider stages (one quotient bit each, set by the restoring
// divider, the first loaded by the queue pop), one scaling multiply and the
// output register.
// The user must write screen width and height on cfg_we/cfg_index/cfg_wdata
// only while the block is idle; the block does not enforce it. Reset loads the
// identity matrix and a 640 by 480 screen.
// When the receiver stalls, the back freezes in place and the queue fills;
// in_stall rises once the queue and front hold as many vertices as the
// queue can keep, so nothing is lost. Load items need no queue space.
// ----------------------------------------------------------------------------
module vertex_project_clip_viewport_core #(
	parameter int FRAC_BITS = vpcv_pkg::FRAC_BITS_DEF,
	parameter int QUEUE_DEPTH = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  vpcv_pkg::in_item_t                in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output vpcv_pkg::out_item_t               out_data,
	input  logic                              cfg_we,
	input  logic [vpcv_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [vpcv_pkg::SIZE_W-1:0]       cfg_wdata
);
	import vpcv_pkg::*;

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic accept;
	logic push;
	clip_item_t push_item;
	clip_item_t head_item;
	logic head_valid;
	logic pop;
	queue_ctl_t qctl;
	logic [SIZE_W-1:0] width_q, height_q;
	// Vertices in the front pipeline or waiting in the queue.
	logic [CNT_W-1:0] credit_q;
	logic take;

	assign accept = in_valid && !in_stall;
	assign take = accept && in_data.op == OP_PROJECT;
	assign in_stall = credit_q == CNT_W'(QUEUE_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			credit_q <= credit_q + CNT_W'(take) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= SIZE_W'(640);
			height_q <= SIZE_W'(480);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SCREEN_WIDTH: width_q <= cfg_wdata;
				REG_SCREEN_HEIGHT: height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	vpcv_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (in_data),
		.push      (push),
		.push_item (push_item)
	);

	assign qctl.push = push;
	assign qctl.pop = pop;

	vpcv_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (qctl),
		.wr_item   (push_item),
		.not_empty (head_valid),
		.rd_item   (head_item)
	);

	vpcv_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_item     (head_item),
		.screen_width  (width_q),
		.screen_height (height_q),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_data      (out_data)
	);

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the vertex projection core
// Loads matrices, projects vertices under random idling and a long output
// hold-off, and compares every projected vertex with a fixed-point predictor.
// ----------------------------------------------------------------------------
module tb_top;
	import vpcv_pkg::*;

	localparam int FB = FRAC_BITS_DEF;
	localparam int LAT = 60;
	localparam int WATCHDOG = 20000;

	// Keeps the predicted matrix and screen size and the queue of expected
	// projected vertices; checks each output transfer against the oldest one.
	class proj_scoreboard;
		logic [31:0] mtx[16];
		logic [11:0] width_px, height_px;
		out_item_t pending[$];
		int mismatches;

		function void reset_state();
			for (int i = 0; i < 16; i++)
				mtx[i] = (i % 5 == 0) ? 32'h1 << FB : 32'h0;
			width_px = 640;
			height_px = 480;
			pending.delete();
			mismatches = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [11:0] val);
			if (idx == REG_SCREEN_WIDTH)
				width_px = val;
			else if (idx == REG_SCREEN_HEIGHT)
				height_px = val;
		endfunction

		// floor((num / (2*den)) * 2^32) then scale by size*16, rounded and capped at size*16.
		function logic [15:0] to_pixels(logic [63:0] num, logic [63:0] den, logic [11:0] sz);
			logic [127:0] q, r, d, s, lim;
			d = {64'h0, den} << 1;
			r = {64'h0, num};
			q = 0;
			if (r >= d) begin
				r = r - d;
				q = 1;
			end
			for (int i = 0; i < 32; i++) begin
				r = r << 1;
				q = q << 1;
				if (r >= d) begin
					r = r - d;
					q[0] = 1'b1;
				end
			end
			s = (q * sz * 16 + 128'h8000_0000) >> 32;
			lim = sz * 16;
			if (s > lim)
				s = lim;
			return s[15:0];
		endfunction

		function void note_input(in_item_t it);
			longint signed cl[4], v[3], aw, cx, cy, cw;
			out_item_t res;
			if (it.op == OP_LOAD) begin
				mtx[it.coef_index] = it.coef_value;
				return;
			end
			v[0] = it.vertex_x;
			v[1] = it.vertex_y;
			v[2] = it.vertex_z;
			for (int r = 0; r < 4; r++) begin
				cl[r] = longint'(signed'(mtx[r*4+3]));
				// Arithmetic shift floors toward minus infinity.
				for (int k = 0; k < 3; k++)
					cl[r] += (longint'(signed'(mtx[r*4+k])) * v[k]) >>> FB;
			end
			cx = cl[0];
			cy = cl[1];
			cw = cl[3];
			aw = cw < 0 ? -cw : cw;
			res = '0;
			// A w so small that it scales below one unit at 2^-16 gives an invisible result.
			if (!(aw < (64'sd1 << FB) && ((aw << 16) < (64'sd1 << FB)))) begin
				if (!((cx < 0 ? -cx : cx) > aw || (cy < 0 ? -cy : cy) > aw ||
						(cl[2] < 0 ? -cl[2] : cl[2]) > aw)) begin
					if (cw < 0) begin
						cw = -cw;
						cx = -cx;
						cy = -cy;
					end
					res.visible = 1'b1;
					res.screen_x = to_pixels(cw + cx, cw, width_px);
					res.screen_y = to_pixels(cw - cy, cw, height_px);
				end
			end
			pending.push_back(res);
		endfunction

		function void check_output(out_item_t got);
			out_item_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected output transfer %p", got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected %p, got %p", want, got);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 0;
	out_item_t out_data;
	logic cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [SIZE_W-1:0] cfg_wdata = '0;

	proj_scoreboard sb = new();
	bit no_idle = 0;
	bit hold_off = 0;
	bit feeding_done = 0;
	int quiet_cycles = 0;

	vertex_project_clip_viewport_core uut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// Output side: random stalls, except in the calm stretch; the hold-off
	// stalls steadily so the queue fills and the input is pushed back.
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			sb.check_output(out_data);
		out_stall <= hold_off || (!no_idle && $urandom_range(99) < 19);
	end

	// Watchdog on cycles with no transfer at all.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG && !feeding_done) begin
			$display("vertex_project_clip_viewport_core test failed");
			$finish;
		end
	end

	// One input transfer, with a random idle gap in front of it. Valid stays
	// up after a transfer so that the next item can follow without a gap.
	task automatic send_item(in_item_t it);
		while (!no_idle && $urandom_range(99) < 19) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_input(it);
	endtask

	task automatic send_load(int idx, logic [31:0] val);
		in_item_t it;
		it = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
		it.op = OP_LOAD;
		it.coef_index = 4'(idx);
		it.coef_value = val;
		send_item(it);
	endtask

	task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		in_item_t it;
		it = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
		it.op = OP_PROJECT;
		it.vertex_x = x;
		it.vertex_y = y;
		it.vertex_z = z;
		send_item(it);
	endtask

	// Waits until all projected vertices are back, then for trailing loads.
	task automatic drain();
		int n;
		n = 0;
		in_valid <= 1'b0;
		while (sb.pending.size() != 0 && n < 200000) begin
			@(posedge clk);
			n++;
		end
		repeat (LAT) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [11:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	// A small random coordinate between -2 and 2 units.
	function automatic logic [31:0] small_coord();
		return 32'($signed($urandom_range(0, 4 << FB)) - (2 << FB));
	endfunction

	task automatic load_perspective();
		// Random scale on the diagonal, w taken from -z plus an offset.
		for (int i = 0; i < 16; i++)
			send_load(i, 0);
		send_load(0, $urandom_range(1 << FB, 3 << FB));
		send_load(5, $urandom_range(1 << FB, 3 << FB));
		send_load(10, $urandom_range(1 << (FB - 2), 1 << FB));
		send_load(14, -(32'sd1 << FB));
		send_load(15, $urandom_range(0, 2) << FB);
	endtask

	task automatic random_phase(int count);
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(9))
				0: send_load($urandom_range(15), small_coord());
				1: send_load($urandom_range(15), $urandom);
				2: send_vertex($urandom, $urandom, $urandom);
				3: send_vertex(small_coord(), small_coord(), $urandom);
				default: send_vertex(small_coord(), small_coord(),
					32'($signed($urandom_range(0, 8 << FB)) - (9 << FB)));
			endcase
		end
	endtask

	initial begin
		logic [11:0] sizes[6];
		sb.reset_state();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: identity matrix, corners of the clip cube, field extremes.
		send_vertex(0, 0, 0);
		send_vertex(32'h1 << FB, 32'h1 << FB, 32'h1 << FB);
		send_vertex(-(32'sd1 << FB), -(32'sd1 << FB), -(32'sd1 << FB));
		send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 0);
		send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_vertex((32'h1 << FB) + 1, 0, 0);
		// w near zero: exactly zero, smallest positive, smallest negative.
		send_load(15, 0);
		send_vertex(0, 0, 0);
		send_load(15, 1);
		send_vertex(0, 0, 0);
		send_load(15, -1);
		send_vertex(0, 0, 0);
		// Negative w flips the numerators.
		send_load(15, -(32'sd1 << FB));
		send_vertex(32'h8000, 32'hFFFF_8000, 0);
		send_load(0, 32'h7FFF_FFFF);
		send_load(3, 32'h8000_0000);
		send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_load(15, 32'h7FFF_FFFF);
		send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		drain();

		// Phases across screen sizes, the extremes and zero among them.
		sizes = '{12'd1, 12'd4095, 12'd0, 12'd640, 12'd1919, 12'd3};
		for (int p = 0; p < 6; p++) begin
			write_reg(REG_SCREEN_WIDTH, sizes[p]);
			write_reg(REG_SCREEN_HEIGHT, sizes[(p + 1) % 6]);
			no_idle = (p == 2);
			load_perspective();
			if (p == 3) begin
				// Long output hold-off while the input keeps offering items.
				fork
					begin
						hold_off = 1;
						repeat (300) @(posedge clk);
						hold_off = 0;
					end
					random_phase(60);
				join
			end
			random_phase(220);
			drain();
		end
		no_idle = 0;
		write_reg(REG_SCREEN_WIDTH, 12'($urandom_range(1, 4095)));
		write_reg(REG_SCREEN_HEIGHT, 12'($urandom_range(1, 4095)));
		random_phase(100);
		drain();
		feeding_done = 1;

		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("vertex_project_clip_viewport_core test passed");
		else
			$display("vertex_project_clip_viewport_core test failed");
		$finish;
	end

endmodule

// ===== sim.f =====
design/vpcv_pkg.sv
design/vpcv_front.sv
design/vpcv_queue.sv
design/vpcv_back.sv
design/vertex_project_clip_viewport_core.sv
tb/tb_top.sv
